### sv/psd_pkg.sv
// Package for the pseudo-DES counter random generator.
// Holds the round keys, codes, shared types and the Feistel round function.
// No dependencies.
package psd_pkg;

  localparam int ROUNDS = 4;
  localparam int WORD_W = 32;
  localparam int HALF_W = 16;
  localparam int KEY_COUNT = 4;
  localparam int RND_W = $clog2(KEY_COUNT);
  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_HASH = 1'b1;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_HIGH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LOW  = 1'b1;

  localparam logic [WORD_W-1:0] KEY_A [KEY_COUNT] = '{
    32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
  };
  localparam logic [WORD_W-1:0] KEY_B [KEY_COUNT] = '{
    32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
  };

  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } psd_word_t;

  typedef struct packed {
    logic      valid;
    psd_word_t data;
  } psd_head_t;

  function automatic psd_word_t psd_round(input psd_word_t w, input logic [RND_W-1:0] rnd);
    logic [WORD_W-1:0] a;
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [WORD_W-1:0] lolo;
    logic [WORD_W-1:0] hihi;
    logic [WORD_W-1:0] lohi;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    psd_word_t         res;
    a = w.right ^ KEY_A[rnd];
    lo = a[HALF_W-1:0];
    hi = a[WORD_W-1:HALF_W];
    lolo = WORD_W'(lo) * WORD_W'(lo);
    hihi = WORD_W'(hi) * WORD_W'(hi);
    lohi = WORD_W'(lo) * WORD_W'(hi);
    b = lolo + ~hihi;
    c = {b[HALF_W-1:0], b[WORD_W-1:HALF_W]};
    res.right = w.left ^ ((c ^ KEY_B[rnd]) + lohi);
    res.left = w.right;
    return res;
  endfunction

endpackage

### sv/psd_front.sv
// Front end: accepts items, holds the seeds and the 64-bit counter,
// and turns each item into a 64-bit word for the round engine. Uses psd_pkg.
module psd_front import psd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [WORD_W-1:0]      word_high,
  input  logic [WORD_W-1:0]      word_low,
  input  logic                   q_full,
  output logic                   push,
  output psd_word_t              push_data
);

  logic [WORD_W-1:0]   seed_high;
  logic [WORD_W-1:0]   seed_low;
  logic [2*WORD_W-1:0] counter;
  logic [2*WORD_W-1:0] counter_next;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;
  assign counter_next = counter + 64'd1;

  always_comb begin
    if (operation == OP_HASH) begin
      push_data.left = word_high;
      push_data.right = word_low;
    end else begin
      push_data.left = counter[2*WORD_W-1:WORD_W];
      push_data.right = counter[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_high <= '0;
      seed_low <= '0;
      counter <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEED_HIGH: begin
          seed_high <= cfg_data;
          counter <= {cfg_data, seed_low};
        end
        REG_SEED_LOW: begin
          seed_low <= cfg_data;
          counter <= {seed_high, cfg_data};
        end
        default: ;
      endcase
    end else if (push && operation == OP_DRAW) begin
      counter <= counter_next;
    end
  end

endmodule

### sv/psd_queue.sv
// Short queue of 64-bit words between the front end and the round engine.
// Uses psd_pkg.
module psd_queue import psd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  psd_word_t push_data,
  output logic      full,
  input  logic      pop,
  output psd_head_t head
);

  psd_word_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full = count == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/psd_back.sv
// Round engine: one Feistel round per cycle unless the output stalls,
// then an output register. Uses psd_pkg.
module psd_back import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  psd_head_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] result_high,
  output logic [WORD_W-1:0] result_low
);

  logic             busy;
  logic [RND_W-1:0] rnd;
  psd_word_t        work;
  psd_word_t        round_in;
  psd_word_t        round_out;
  logic             last;
  logic             out_free;
  logic             step;

  assign round_in = busy ? work : head.data;
  assign round_out = psd_round(round_in, rnd);
  assign last = rnd == LAST_ROUND;
  assign out_free = !out_valid || !out_stall;
  assign step = (busy || head.valid) && (!last || out_free);
  assign pop = step && !busy;

  always_ff @(posedge clk) begin
    if (step) begin
      work <= round_out;
    end
    if (step && last) begin
      result_high <= round_out.left;
      result_low <= round_out.right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        if (last) begin
          busy <= 1'b0;
          rnd <= '0;
        end else begin
          busy <= 1'b1;
          rnd <= rnd + 1'b1;
        end
      end
      if (step && last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/psdes_counter_random_generator.sv
// Top level of the pseudo-DES counter random generator.
// Depends on psd_pkg, psd_front, psd_queue and psd_back.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  operation, word_high, word_low
//   out      out_valid / out_stall result_high, result_low
//   cfg      cfg_write            cfg_index, cfg_data
//
// Each item passes the round engine one Feistel round per cycle, on three 16x16
// multipliers, while the output does not stall; the engine takes the next item
// only after the last round of the one before, and registers each result.
// Reset clears the seeds, the counter, the queue and the engine.
// A stalled output holds the last round; the two-entry queue keeps taking items until full.
module psdes_counter_random_generator import psd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [WORD_W-1:0]      word_high,
  input  logic [WORD_W-1:0]      word_low,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_W-1:0]      result_high,
  output logic [WORD_W-1:0]      result_low
);

  logic      q_full;
  logic      push;
  psd_word_t push_data;
  logic      pop;
  psd_head_t head;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .word_high (word_high),
    .word_low  (word_low),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  psd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  psd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_high (result_high),
    .result_low  (result_low)
  );

endmodule
